/* design/tpe_pkg.sv */
package tpe_pkg;

  localparam int unsigned TPE_CAPTURE_WIDTH = 16;
  localparam int unsigned TPE_FRAC_BITS     = 8;

  localparam int unsigned CAP_IN_W = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned RPM_W    = 32;
  localparam int unsigned MINP_W   = 16;
  localparam int unsigned TMO_W    = 16;
  localparam int unsigned NUM_W    = 24;
  localparam int unsigned BAND_W   = 8;
  localparam int unsigned ALPHA_W  = 9;

  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned S_TUSER_W = 1;
  localparam int unsigned M_TDATA_W = 32;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUMERATOR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA      = 3'd4;

  localparam logic [MINP_W-1:0]  RST_MIN_PERIOD = 16'd400;
  localparam logic [TMO_W-1:0]   RST_TIMEOUT    = 16'd200;
  localparam logic [NUM_W-1:0]   RST_NUMERATOR  = 24'd1250000;
  localparam logic [BAND_W-1:0]  RST_BAND       = 8'd90;
  localparam logic [ALPHA_W-1:0] RST_ALPHA      = 9'd77;

  localparam logic [ALPHA_W-1:0] ALPHA_MAX = 9'd256;

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_POLL = 1'b1;

  localparam int unsigned MUL_STEPS = 9;
  localparam int unsigned PROD_W    = 41;

endpackage

/* design/tachometer_period_ema.sv */
// An edge transfer updates state and yields no result. A poll with no nonzero pending
// period goes to the done state, which registers the result once the output is free.
// Otherwise a bit-serial divider, a range step, a 9-step band multiply and clamp (only
// when the filter exceeds 1.0), a difference, a 9-step alpha multiply and the EMA run.
// Throughput: one item at a time; a new item is taken while the last result waits.
// Reset: asynchronous, active low; config returns to defaults, control state clears.
module tachometer_period_ema #(
  parameter int unsigned CAPTURE_WIDTH = tpe_pkg::TPE_CAPTURE_WIDTH,
  parameter int unsigned FRAC_BITS     = tpe_pkg::TPE_FRAC_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [15:0] capture_count, [47:16] now_ms
  input  logic [tpe_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // [0] op
  input  logic [tpe_pkg::S_TUSER_W-1:0]    s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [31:0] rpm_out
  output logic [tpe_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tpe_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tpe_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import tpe_pkg::*;

  localparam int unsigned CW     = CAPTURE_WIDTH;
  localparam int unsigned SCL_W  = NUM_W + FRAC_BITS;
  localparam int unsigned DVD_W  = ((SCL_W > CW) ? SCL_W : CW) + 1;
  localparam int unsigned CMP_W  = (CW > MINP_W) ? CW : MINP_W;
  localparam int unsigned CNT_W  = $clog2(DVD_W + 1);
  localparam logic [RPM_W-1:0] ONE_FX = RPM_W'(1) << FRAC_BITS;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_RANGE = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_CLAMP = 3'd4;
  localparam logic [2:0] ST_DIFF  = 3'd5;
  localparam logic [2:0] ST_EMA   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]         state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               ema_ph_q, ema_ph_d;
  logic               m_valid_q, m_valid_d;

  logic [MINP_W-1:0]  min_period_q;
  logic [TMO_W-1:0]   timeout_q;
  logic [NUM_W-1:0]   numerator_q;
  logic [BAND_W-1:0]  band_q;
  logic [ALPHA_W-1:0] alpha_q;

  logic [CW-1:0]      last_cap_q, last_cap_d;
  logic [CW-1:0]      pend_period_q, pend_period_d;
  logic               pend_flag_q, pend_flag_d;
  logic [TIME_W-1:0]  last_time_q, last_time_d;
  logic [RPM_W-1:0]   filt_q, filt_d;

  logic [DVD_W-1:0]   dvd_q, dvd_d;
  logic [CW-1:0]      rem_q, rem_d;
  logic [PROD_W-1:0]  mcand_q, mcand_d;
  logic [ALPHA_W-1:0] mplr_q, mplr_d;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [RPM_W-1:0]   fresh_q, fresh_d;
  logic               up_q, up_d;
  logic [RPM_W-1:0]   out_q, out_d;

  logic               in_xfer;
  logic               op;
  logic [CW-1:0]      cap;
  logic [CW-1:0]      dt;
  logic [TIME_W-1:0]  now;
  logic [TIME_W-1:0]  elapsed;
  logic [CW:0]        rem_sh;
  logic               q_bit;
  logic [63:0]        quot;
  logic [RPM_W:0]     hi_w;
  logic [RPM_W-1:0]   hi, lo;
  logic [PROD_W-1:0]  rnd;
  logic [RPM_W-1:0]   delta;
  logic [ALPHA_W-1:0] alpha_eff;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign op            = s_axis_tuser[0];
  assign cap           = CW'(s_axis_tdata[CAP_IN_W-1:0]);
  assign now           = s_axis_tdata[CAP_IN_W +: TIME_W];
  assign dt            = cap - last_cap_q;
  assign elapsed       = now - last_time_q;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;
  assign cfg_ready_o   = 1'b1;

  assign rem_sh    = {rem_q, dvd_q[DVD_W-1]};
  assign q_bit     = (rem_sh >= (CW+1)'(pend_period_q));
  assign quot      = 64'(dvd_q);
  assign hi_w      = (RPM_W+1)'(filt_q) + (RPM_W+1)'(prod_q[39:8]);
  assign hi        = hi_w[RPM_W] ? '1 : hi_w[RPM_W-1:0];
  assign lo        = filt_q - prod_q[39:8] - RPM_W'(|prod_q[7:0]);
  assign rnd       = prod_q + PROD_W'(128);
  assign delta     = rnd[39:8];
  assign alpha_eff = (alpha_q > ALPHA_MAX) ? ALPHA_MAX : alpha_q;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    ema_ph_d      = ema_ph_q;
    m_valid_d     = m_valid_q;
    last_cap_d    = last_cap_q;
    pend_period_d = pend_period_q;
    pend_flag_d   = pend_flag_q;
    last_time_d   = last_time_q;
    filt_d        = filt_q;
    dvd_d         = dvd_q;
    rem_d         = rem_q;
    mcand_d       = mcand_q;
    mplr_d        = mplr_q;
    prod_d        = prod_q;
    fresh_d       = fresh_q;
    up_d          = up_q;
    out_d         = out_q;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (op == OP_EDGE) begin
            last_cap_d = cap;
            if (CMP_W'(dt) > CMP_W'(min_period_q)) begin
              pend_period_d = dt;
              pend_flag_d   = 1'b1;
            end
          end else if (!pend_flag_q) begin
            if (elapsed > TIME_W'(timeout_q)) begin
              filt_d = '0;
            end
            state_d = ST_DONE;
          end else begin
            pend_flag_d = 1'b0;
            last_time_d = now;
            if (pend_period_q == '0) begin
              state_d = ST_DONE;
            end else begin
              dvd_d   = DVD_W'({numerator_q, FRAC_BITS'(0)}) + DVD_W'(pend_period_q >> 1);
              rem_d   = '0;
              cnt_d   = CNT_W'(DVD_W);
              state_d = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        rem_d = q_bit ? CW'(rem_sh - (CW+1)'(pend_period_q)) : CW'(rem_sh);
        dvd_d = {dvd_q[DVD_W-2:0], q_bit};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = ST_RANGE;
        end
      end
      ST_RANGE: begin
        fresh_d = (quot > 64'hFFFF_FFFF) ? '1 : quot[RPM_W-1:0];
        if (filt_q > ONE_FX) begin
          mcand_d  = PROD_W'(filt_q);
          mplr_d   = ALPHA_W'(band_q);
          prod_d   = '0;
          cnt_d    = CNT_W'(MUL_STEPS);
          ema_ph_d = 1'b0;
          state_d  = ST_MUL;
        end else begin
          state_d = ST_DIFF;
        end
      end
      ST_MUL: begin
        prod_d  = prod_q + (mplr_q[0] ? mcand_q : '0);
        mcand_d = {mcand_q[PROD_W-2:0], 1'b0};
        mplr_d  = {1'b0, mplr_q[ALPHA_W-1:1]};
        cnt_d   = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = ema_ph_q ? ST_EMA : ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        if (fresh_q < lo) begin
          fresh_d = lo;
        end else if (fresh_q > hi) begin
          fresh_d = hi;
        end
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        up_d     = (fresh_q >= filt_q);
        mcand_d  = PROD_W'((fresh_q >= filt_q) ? fresh_q - filt_q : filt_q - fresh_q);
        mplr_d   = alpha_eff;
        prod_d   = '0;
        cnt_d    = CNT_W'(MUL_STEPS);
        ema_ph_d = 1'b1;
        state_d  = ST_MUL;
      end
      ST_EMA: begin
        filt_d  = up_q ? filt_q + delta : filt_q - delta;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          out_d     = filt_q;
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      ema_ph_q      <= 1'b0;
      m_valid_q     <= 1'b0;
      last_cap_q    <= '0;
      pend_period_q <= '0;
      pend_flag_q   <= 1'b0;
      last_time_q   <= '0;
      filt_q        <= '0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      ema_ph_q      <= ema_ph_d;
      m_valid_q     <= m_valid_d;
      last_cap_q    <= last_cap_d;
      pend_period_q <= pend_period_d;
      pend_flag_q   <= pend_flag_d;
      last_time_q   <= last_time_d;
      filt_q        <= filt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_period_q <= RST_MIN_PERIOD;
      timeout_q    <= RST_TIMEOUT;
      numerator_q  <= RST_NUMERATOR;
      band_q       <= RST_BAND;
      alpha_q      <= RST_ALPHA;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_MIN_PERIOD: min_period_q <= cfg_data_i[MINP_W-1:0];
        CFG_TIMEOUT:    timeout_q    <= cfg_data_i[TMO_W-1:0];
        CFG_NUMERATOR:  numerator_q  <= cfg_data_i[NUM_W-1:0];
        CFG_BAND:       band_q       <= cfg_data_i[BAND_W-1:0];
        CFG_ALPHA:      alpha_q      <= cfg_data_i[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    mcand_q <= mcand_d;
    mplr_q  <= mplr_d;
    prod_q  <= prod_d;
    fresh_q <= fresh_d;
    up_q    <= up_d;
    out_q   <= out_d;
  end

endmodule

/* verif/tachometer_period_ema_tb.sv */
`timescale 1ns / 1ps

module tachometer_period_ema_tb;
  import tpe_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES  = 120;
  localparam bit [63:0]   SAT_32         = 64'hFFFF_FFFF;

  typedef struct packed {
    logic                op;
    logic [CAP_IN_W-1:0] capture_count;
    logic [TIME_W-1:0]   now_ms;
  } tach_item_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [S_TUSER_W-1:0]  s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = CFG_MIN_PERIOD;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  // predictor configuration and state
  logic [MINP_W-1:0]     min_period_q    = RST_MIN_PERIOD;
  logic [TMO_W-1:0]      timeout_q       = RST_TIMEOUT;
  logic [NUM_W-1:0]      numerator_q     = RST_NUMERATOR;
  logic [BAND_W-1:0]     band_q          = RST_BAND;
  logic [ALPHA_W-1:0]    alpha_q         = RST_ALPHA;
  logic [CAP_IN_W-1:0]   last_capture    = '0;
  logic [CAP_IN_W-1:0]   pending_period  = '0;
  logic                  pending_flag    = 1'b0;
  logic [TIME_W-1:0]     last_pulse_time = '0;
  logic [RPM_W-1:0]      filtered_rpm    = '0;

  tach_item_t            sensor_item_q[$];
  logic [RPM_W-1:0]      rpm_expect_q[$];
  tach_item_t            drive_item;
  logic [RPM_W-1:0]      rpm_want;
  bit                    no_stall        = 1'b0;
  int unsigned           mismatch_cnt    = 0;
  int unsigned           quiet_cycles    = 0;
  bit [CAP_IN_W-1:0]     gen_cap         = '0;
  bit [TIME_W-1:0]       gen_now         = '0;

  always #1 clk_i = ~clk_i;

  tachometer_period_ema u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  function automatic logic [RPM_W-1:0] blend_period(input logic [CAP_IN_W-1:0] period);
    bit [63:0] fresh;
    bit [63:0] cur;
    bit [63:0] lo;
    bit [63:0] hi;
    bit [63:0] wgt;
    wgt   = (alpha_q > ALPHA_MAX) ? 64'(ALPHA_MAX) : 64'(alpha_q);
    fresh = ((64'(numerator_q) << TPE_FRAC_BITS) + 64'(period >> 1)) / 64'(period);
    if (fresh > SAT_32) fresh = SAT_32;
    cur = 64'(filtered_rpm);
    if (cur > (64'd1 << TPE_FRAC_BITS)) begin
      lo = (cur * (64'd256 - 64'(band_q))) >> 8;
      hi = (cur * (64'd256 + 64'(band_q))) >> 8;
      if (hi > SAT_32) hi = SAT_32;
      if (fresh < lo) fresh = lo;
      else if (fresh > hi) fresh = hi;
    end
    if (fresh >= cur) cur = cur + ((wgt * (fresh - cur) + 64'd128) >> 8);
    else cur = cur - ((wgt * (cur - fresh) + 64'd128) >> 8);
    if (cur > SAT_32) cur = SAT_32;
    return cur[RPM_W-1:0];
  endfunction

  task automatic track_item(input tach_item_t it);
    logic [CAP_IN_W-1:0] dt;
    logic [TIME_W-1:0]   elapsed;
    dt      = it.capture_count - last_capture;
    elapsed = it.now_ms - last_pulse_time;
    if (it.op == OP_EDGE) begin
      last_capture = it.capture_count;
      if (dt > min_period_q) begin
        pending_period = dt;
        pending_flag   = 1'b1;
      end
    end else begin
      if (!pending_flag) begin
        if (elapsed > TIME_W'(timeout_q)) filtered_rpm = '0;
      end else begin
        pending_flag    = 1'b0;
        last_pulse_time = it.now_ms;
        if (pending_period != '0) filtered_rpm = blend_period(pending_period);
      end
      rpm_expect_q.push_back(filtered_rpm);
    end
  endtask

  task automatic note_mismatch(input string what, input logic [RPM_W-1:0] want,
                               input logic [RPM_W-1:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("mismatch %0s: rpm_out expected 0x%08h got 0x%08h", what, want, got);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) track_item(drive_item);
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (sensor_item_q.size() != 0 && (no_stall || $urandom_range(99) >= 11)) begin
        drive_item = sensor_item_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {drive_item.now_ms, drive_item.capture_count};
        s_axis_tuser  <= drive_item.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (rpm_expect_q.size() == 0) begin
        note_mismatch("unexpected transfer", '0, m_axis_tdata);
      end else begin
        rpm_want = rpm_expect_q.pop_front();
        if (m_axis_tdata !== rpm_want) note_mismatch("poll result", rpm_want, m_axis_tdata);
      end
    end
    m_axis_tready <= rst_ni && (no_stall || $urandom_range(99) >= 11);
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tachometer_period_ema test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic add_edge(input logic [CAP_IN_W-1:0] cap);
    tach_item_t it;
    it.op            = OP_EDGE;
    it.capture_count = cap;
    it.now_ms        = $urandom;
    sensor_item_q.push_back(it);
  endtask

  task automatic add_poll(input logic [TIME_W-1:0] now);
    tach_item_t it;
    it.op            = OP_POLL;
    it.capture_count = CAP_IN_W'($urandom);
    it.now_ms        = now;
    sensor_item_q.push_back(it);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_MIN_PERIOD: min_period_q = val[MINP_W-1:0];
      CFG_TIMEOUT:    timeout_q    = val[TMO_W-1:0];
      CFG_NUMERATOR:  numerator_q  = val[NUM_W-1:0];
      CFG_BAND:       band_q       = val[BAND_W-1:0];
      CFG_ALPHA:      alpha_q      = val[ALPHA_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (sensor_item_q.size() != 0 || s_axis_tvalid || rpm_expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic gen_traffic(input int unsigned n_items, input int unsigned minp,
                             input int unsigned tmo);
    int unsigned added;
    int unsigned kind;
    int unsigned lo;
    int unsigned period;
    int unsigned step;
    added = 0;
    lo    = (minp >= 65535) ? 65535 : minp + 1;
    while (added < n_items) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        case ($urandom_range(2))
          0:       period = lo + $urandom_range(300);
          1:       period = lo + $urandom_range(4000);
          default: period = $urandom_range(lo, 65535);
        endcase
        if (period > 65535) period = 65535;
        repeat ($urandom_range(2, 8)) begin
          case ($urandom_range(19))
            0:       step = period * 3;
            1:       step = period / 3;
            2:       step = $urandom_range(minp);
            default: step = period - period / 16 + $urandom_range(period / 8);
          endcase
          gen_cap += step[CAP_IN_W-1:0];
          add_edge(gen_cap);
          added++;
          if ($urandom_range(1) == 1) begin
            gen_now += $urandom_range(1, 30);
            add_poll(gen_now);
            added++;
          end
        end
        gen_now += $urandom_range(1, 30);
        add_poll(gen_now);
        added++;
      end else if (kind < 88) begin
        case ($urandom_range(3))
          0:       gen_now += tmo;
          1:       gen_now += tmo + 1;
          2:       gen_now += (tmo > 0) ? tmo - 1 : 0;
          default: gen_now += $urandom;
        endcase
        add_poll(gen_now);
        added++;
      end else begin
        gen_cap = CAP_IN_W'($urandom);
        add_edge(gen_cap);
        gen_now = $urandom;
        add_poll(gen_now);
        added += 2;
      end
    end
  endtask

  task automatic run_phase(input int unsigned minp, input int unsigned tmo,
                           input int unsigned num, input int unsigned band,
                           input int unsigned alpha, input int unsigned n_items,
                           input bit quiet);
    cfg_write(CFG_MIN_PERIOD, CFG_DATA_W'(minp));
    cfg_write(CFG_TIMEOUT, CFG_DATA_W'(tmo));
    cfg_write(CFG_NUMERATOR, CFG_DATA_W'(num));
    cfg_write(CFG_BAND, CFG_DATA_W'(band));
    cfg_write(CFG_ALPHA, CFG_DATA_W'(alpha));
    no_stall = quiet;
    gen_traffic(n_items, minp, tmo);
    drain();
    no_stall = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_edge(16'h0000);
    add_poll(32'd0);
    add_edge(16'h0190);
    add_edge(16'h0321);
    add_poll(32'd10);
    add_edge(16'hFFFF);
    add_edge(16'h0F00);
    add_poll(32'd20);
    add_edge(16'h1400);
    add_poll(32'd30);
    add_edge(16'h8EB0);
    add_poll(32'd40);
    add_edge(16'h9041);
    add_poll(32'd50);
    add_poll(32'd250);
    add_poll(32'd251);
    add_edge(16'hA000);
    add_poll(32'hFFFF_FFF0);
    add_poll(32'h0000_0010);
    add_poll(32'h5A5A_5A5A);
    add_edge(16'h5555);
    add_edge(16'hAAAA);
    add_poll(32'hA5A5_A5A5);
    drain();

    run_phase(400, 200, 1250000, 90, 77, 200, 1'b0);
    run_phase(0, 0, 16777215, 255, 256, 200, 1'b0);
    run_phase(65535, 65535, 1, 0, 0, 80, 1'b0);
    gen_now = 32'hFFFF_F000;
    run_phase(1000, 50, 5000000, 30, 128, 200, 1'b0);
    run_phase(16, 1000, 0, 128, 511, 150, 1'b0);
    run_phase(200, 300, 3000000, 64, 200, 220, 1'b1);
    run_phase($urandom_range(3000), $urandom_range(500), $urandom_range(1, 16777215),
              $urandom_range(255), $urandom_range(256), 200, 1'b0);
    run_phase($urandom_range(3000), $urandom_range(500), $urandom_range(1, 16777215),
              $urandom_range(255), $urandom_range(256), 200, 1'b0);

    if (mismatch_cnt == 0) begin
      $display("tachometer_period_ema test passed");
    end else begin
      $display("tachometer_period_ema test failed");
    end
    $finish;
  end

endmodule
